// ----- rtl/word_stream_mix_hash_top_macros.svh -----
// ----------------------------------------------------------------------------
// Word stream mix hash - assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef WORD_STREAM_MIX_HASH_TOP_MACROS_SVH
`define WORD_STREAM_MIX_HASH_TOP_MACROS_SVH

// same-cycle implication
`define WSMH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/wsmh_pkg.sv -----
// ----------------------------------------------------------------------------
// Word stream mix hash - package
// Widths, seeds, lane codes and the queue entry type.
// ----------------------------------------------------------------------------
package wsmh_pkg;

   localparam int WORD_BITS      = 64;
   localparam int LEN_BITS       = 32;
   localparam int REQ_DATA_BITS  = WORD_BITS + LEN_BITS;
   localparam int RSP_DATA_BITS  = WORD_BITS;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [WORD_BITS-1:0] SEED_A = 64'h0000_0000_ba5e_bee7;
   localparam logic [WORD_BITS-1:0] SEED_B = 64'h0000_0000_cafe_babe;

   // mix runs one line per cycle; the final line waits while a hash is unread
   localparam int MIX_STEPS = 12;
   localparam int STEP_BITS = $clog2(MIX_STEPS);
   localparam logic [STEP_BITS-1:0] MIX_LAST_STEP = STEP_BITS'(MIX_STEPS - 1);

   // lane that takes a word (also the lane a mix line updates)
   localparam logic [1:0] LANE_A = 2'd0;
   localparam logic [1:0] LANE_B = 2'd1;
   localparam logic [1:0] LANE_C = 2'd2;

   // classified beat handed from front to back
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [LEN_BITS-1:0]  len;
      logic [1:0]           lane;
      logic                 seed;   // first word of a message
      logic                 mix;    // run the mix after the add
      logic                 emit;   // deliver c when done
      logic                 empty;  // empty message, deliver len
   } wsmh_entry_type;

endpackage

// ----- rtl/wsmh_front.sv -----
// ----------------------------------------------------------------------------
// Word stream mix hash - front end
// Accepts request beats, tracks message position and triple slot, and
// classifies each beat into a queue entry.
// ----------------------------------------------------------------------------
module wsmh_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wsmh_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tuser,
   output logic                                push,
   output wsmh_pkg::wsmh_entry_type            push_entry,
   input  logic                                queue_full
);
   import wsmh_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       in_msg_ff, in_msg_in;
   logic [1:0] slot_cur;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // classify the beat
   always_comb begin
      slot_cur  = in_msg_ff ? slot_ff : LANE_A;
      slot_in   = slot_ff;
      in_msg_in = in_msg_ff;

      push_entry.word  = req_tdata[WORD_BITS-1:0];
      push_entry.len   = req_tdata[REQ_DATA_BITS-1:WORD_BITS];
      push_entry.lane  = (slot_cur == LANE_C || slot_cur == LANE_B) ? slot_cur : LANE_A;
      push_entry.seed  = !in_msg_ff;
      // a last word always leaves a partial or full triple to mix
      push_entry.mix   = (slot_cur == LANE_C) || req_tlast;
      push_entry.emit  = req_tlast;
      push_entry.empty = req_tuser;

      if (req_tuser) begin
         push_entry.mix  = 1'b0;
         push_entry.emit = 1'b0;
         slot_in         = LANE_A;
         in_msg_in       = 1'b0;
      end else begin
         case (push_entry.lane)
            LANE_A:  slot_in = LANE_B;
            LANE_B:  slot_in = LANE_C;
            default: slot_in = LANE_A;
         endcase
         if (req_tlast) begin
            slot_in   = LANE_A;
            in_msg_in = 1'b0;
         end else begin
            in_msg_in = 1'b1;
         end
      end
   end

   // message position
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= LANE_A;
         in_msg_ff <= 1'b0;
      end else if (push) begin
         slot_ff   <= slot_in;
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

// ----- rtl/wsmh_queue.sv -----
// ----------------------------------------------------------------------------
// Word stream mix hash - entry queue
// Small flip-flop FIFO between front and back ends.
// ----------------------------------------------------------------------------
`include "word_stream_mix_hash_top_macros.svh"

module wsmh_queue #(
   parameter int DEPTH = wsmh_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wsmh_pkg::wsmh_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output wsmh_pkg::wsmh_entry_type  head_entry
);
   import wsmh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsmh_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   `WSMH_ASSERT_NOW(a_no_push_full, clock, reset, push, !full, "push into full queue")
   `WSMH_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, head_valid, "pop from empty queue")

endmodule

// ----- rtl/wsmh_back.sv -----
// ----------------------------------------------------------------------------
// Word stream mix hash - back end
// Holds the a/b/c lanes, adds words, runs the 12-line mix one line per cycle
// (final line held while a hash is unread), drives the response register.
// ----------------------------------------------------------------------------
`include "word_stream_mix_hash_top_macros.svh"

module wsmh_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  wsmh_pkg::wsmh_entry_type            head_entry,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wsmh_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import wsmh_pkg::*;

   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                 mixing_ff, mixing_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 emit_pend_ff, emit_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0] mix_src;
   logic [1:0]           mix_role;
   logic [WORD_BITS-1:0] line_a, line_b, line_c;
   logic [WORD_BITS-1:0] base_a, base_b, base_c;
   logic                 out_free;
   logic                 hold_last;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // lane updated by this mix line and its shifted xor term
   always_comb begin
      case (step_ff)
         4'd0:    begin mix_role = LANE_A; mix_src = c_ff >> 43; end
         4'd1:    begin mix_role = LANE_B; mix_src = a_ff << 9;  end
         4'd2:    begin mix_role = LANE_C; mix_src = b_ff >> 8;  end
         4'd3:    begin mix_role = LANE_A; mix_src = c_ff >> 38; end
         4'd4:    begin mix_role = LANE_B; mix_src = a_ff << 23; end
         4'd5:    begin mix_role = LANE_C; mix_src = b_ff >> 5;  end
         4'd6:    begin mix_role = LANE_A; mix_src = c_ff >> 35; end
         4'd7:    begin mix_role = LANE_B; mix_src = a_ff << 49; end
         4'd8:    begin mix_role = LANE_C; mix_src = b_ff >> 11; end
         4'd9:    begin mix_role = LANE_A; mix_src = c_ff >> 12; end
         4'd10:   begin mix_role = LANE_B; mix_src = a_ff << 18; end
         4'd11:   begin mix_role = LANE_C; mix_src = b_ff >> 22; end
         default: begin mix_role = LANE_A; mix_src = '0;         end
      endcase
   end

   assign line_a = (a_ff - (b_ff + c_ff)) ^ mix_src;
   assign line_b = (b_ff - (c_ff + a_ff)) ^ mix_src;
   assign line_c = (c_ff - (a_ff + b_ff)) ^ mix_src;

   // seed on the first word of a message
   assign base_a = head_entry.seed ? SEED_A : a_ff;
   assign base_b = head_entry.seed ? SEED_B : b_ff;
   assign base_c = head_entry.seed ? WORD_BITS'(head_entry.len) : c_ff;

   // final line waits while a delivered hash is still unread
   assign hold_last = (step_ff == MIX_LAST_STEP) && emit_pend_ff && !out_free;

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      mixing_in    = mixing_ff;
      step_in      = step_ff;
      emit_pend_in = emit_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;

      if (mixing_ff) begin
         if (!hold_last) begin
            case (mix_role)
               LANE_B:  b_in = line_b;
               LANE_C:  c_in = line_c;
               default: a_in = line_a;
            endcase
            if (step_ff == MIX_LAST_STEP) begin
               mixing_in = 1'b0;
               step_in   = '0;
               if (emit_pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = line_c;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
      end else if (head_valid) begin
         if (head_entry.empty) begin
            // empty message: hash is the length
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = WORD_BITS'(head_entry.len);
            end
         end else if (!(head_entry.emit && !head_entry.mix) || out_free) begin
            pop  = 1'b1;
            a_in = base_a;
            b_in = base_b;
            c_in = base_c;
            case (head_entry.lane)
               LANE_B:  b_in = base_b + head_entry.word;
               LANE_C:  c_in = base_c + head_entry.word;
               default: a_in = base_a + head_entry.word;
            endcase
            if (head_entry.mix) begin
               mixing_in    = 1'b1;
               step_in      = '0;
               emit_pend_in = head_entry.emit;
            end else if (head_entry.emit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = c_in;
            end
         end
      end
   end

   // lanes and response data
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         mixing_ff    <= 1'b0;
         step_ff      <= '0;
         emit_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mixing_ff    <= mixing_in;
         step_ff      <= step_in;
         emit_pend_ff <= emit_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `WSMH_ASSERT_NOW(a_step_range, clock, reset, mixing_ff, step_ff <= MIX_LAST_STEP, "mix step out of range")
   `WSMH_ASSERT_NOW(a_idle_step, clock, reset, !mixing_ff, step_ff == '0, "idle with nonzero step")
   `WSMH_ASSERT_NEXT(a_mix_start, clock, reset, pop && head_entry.mix, mixing_ff && step_ff == '0, "mix did not start")

endmodule

// ----- rtl/word_stream_mix_hash_top.sv -----
// ----------------------------------------------------------------------------
// Word stream mix hash - top level
// 64-bit three-lane mix hash over a stream of words.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one word per beat: tdata = {bit_length, data_word},
//   tlast marks the final word, tuser marks an empty message (no words,
//   hash is bit_length at once). bit_length is taken on a message's first
//   beat. One rsp beat (the 64-bit hash) follows each last word and each
//   empty message.
//   Flow: the back end takes one queued beat per cycle for plain word adds
//   while it is not mixing; a beat that closes a triple or ends the message
//   starts the mix, one mix line per cycle, the final line waiting while a
//   delivered hash is unread. The front accepts into a QUEUE_DEPTH-entry
//   queue whenever it is not full, independent of the back end.
//   Reset clears the queue, the message position and the response valid.
//   A stalled rsp holds its beat; the back end keeps working until it has a
//   further hash to deliver, then waits on a final mix line or empty message.
// ----------------------------------------------------------------------------
module word_stream_mix_hash_top #(
   parameter int QUEUE_DEPTH = wsmh_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wsmh_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // data_word, bit_length
   input  logic                                req_tlast,   // last_word
   input  logic                                req_tuser,   // empty_message
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wsmh_pkg::RSP_DATA_BITS-1:0]  rsp_tdata    // hash_value
);
   import wsmh_pkg::*;

   logic           push, queue_full, pop, head_valid;
   wsmh_entry_type push_entry, head_entry;

   wsmh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   wsmh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   wsmh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- tb/sv/word_stream_mix_hash_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Word stream mix hash - testbench
// Streams word messages into the hash block and checks every hash beat.
// A directed table covers empty messages, word extremes, messages of one to
// four and of six words, an abandoned message and a length that disagrees with
// the word count. Random messages follow. Every accepted req beat runs through
// a local predictor of the three-lane mix, and each rsp beat is compared with
// the oldest predicted hash. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module word_stream_mix_hash_top_tb;
   import wsmh_pkg::*;

   localparam int RANDOM_BEATS = 1150;
   localparam int DRAIN_CYCLES = 60;

   // one row of the directed table; hash is typed in only where known is set
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [LEN_BITS-1:0]  len;
      logic                 last;
      logic                 empty;
      logic                 known;
      logic [WORD_BITS-1:0] hash;
   } stim_row_type;

   localparam int ROW_COUNT = 22;
   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      // empty messages: hash is the length itself
      '{64'h0000_0000_0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0000, 32'hffff_ffff, 1'b0, 1'b1, 1'b1, 64'h0000_0000_ffff_ffff},
      // empty wins over last
      '{64'hffff_ffff_ffff_ffff, 32'h0000_0040, 1'b1, 1'b1, 1'b1, 64'h0000_0000_0000_0040},
      // one-word messages at the extremes
      '{64'hffff_ffff_ffff_ffff, 32'h0000_0040, 1'b1, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 32'hffff_ffff, 1'b1, 1'b0, 1'b0, 64'h0},
      // two words: partial triple in a and b
      '{64'h0123_4567_89ab_cdef, 32'h0000_0080, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'hfedc_ba98_7654_3210, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 64'h0},
      // three words: one full triple, no final mix
      '{64'h0000_0000_0000_0000, 32'h0000_00c0, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h8000_0000_0000_0001, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 64'h0},
      // four words: full triple then one word in a
      '{64'haaaa_aaaa_aaaa_aaaa, 32'h0000_0100, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h0000_ffff_0000_ffff, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'hffff_0000_ffff_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 64'h0},
      // message abandoned by an empty message
      '{64'h0000_0000_0000_0001, 32'h0000_0064, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 32'hdead_beef, 1'b0, 1'b1, 1'b1, 64'h0000_0000_dead_beef},
      // six words under a length of five bits
      '{64'h1111_1111_1111_1111, 32'h0000_0005, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h2222_2222_2222_2222, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h3333_3333_3333_3333, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h4444_4444_4444_4444, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h7fff_ffff_ffff_ffff, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 64'h0},
      '{64'h8000_0000_0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 64'h0}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // data_word, bit_length
   logic                     req_tlast;   // last_word
   logic                     req_tuser;   // empty_message
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // hash_value

   word_stream_mix_hash_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: the three lanes and the message position
   logic [WORD_BITS-1:0] lane_a;
   logic [WORD_BITS-1:0] lane_b;
   logic [WORD_BITS-1:0] lane_c;
   logic [1:0]           next_lane;
   logic                 msg_open;

   logic [WORD_BITS-1:0] hash_expected [$];
   logic [WORD_BITS-1:0] oldest_hash;
   int                   fail_count = 0;
   int                   beats_sent = 0;
   int                   stall_left = 0;
   logic                 quiet_stretch = 1'b0;

   // twelve mix lines, all shifts logical, all arithmetic mod 2^64
   function automatic void mix_lanes();
      logic [WORD_BITS-1:0] a, b, c;
      a = lane_a;
      b = lane_b;
      c = lane_c;
      a = a - (b + c);  a = a ^ (c >> 43);
      b = b - (c + a);  b = b ^ (a << 9);
      c = c - (a + b);  c = c ^ (b >> 8);
      a = a - (b + c);  a = a ^ (c >> 38);
      b = b - (c + a);  b = b ^ (a << 23);
      c = c - (a + b);  c = c ^ (b >> 5);
      a = a - (b + c);  a = a ^ (c >> 35);
      b = b - (c + a);  b = b ^ (a << 49);
      c = c - (a + b);  c = c ^ (b >> 11);
      a = a - (b + c);  a = a ^ (c >> 12);
      b = b - (c + a);  b = b ^ (a << 18);
      c = c - (a + b);  c = c ^ (b >> 22);
      lane_a = a;
      lane_b = b;
      lane_c = c;
   endfunction

   function automatic void seed_lanes(input logic [LEN_BITS-1:0] len);
      lane_a    = SEED_A;
      lane_b    = SEED_B;
      lane_c    = {{(WORD_BITS-LEN_BITS){1'b0}}, len};
      next_lane = LANE_A;
   endfunction

   // advance the predictor by one beat; returns 1 when a hash comes out
   function automatic logic hash_step(input logic [WORD_BITS-1:0] word,
                                      input logic [LEN_BITS-1:0] len,
                                      input logic last, input logic empty,
                                      output logic [WORD_BITS-1:0] hash);
      // empty message drops any message in progress
      if (empty) begin
         seed_lanes(len);
         msg_open = 1'b0;
         hash     = lane_c;
         return 1'b1;
      end
      if (!msg_open) begin
         seed_lanes(len);
         msg_open = 1'b1;
      end
      case (next_lane)
         LANE_B: begin
            lane_b    = lane_b + word;
            next_lane = LANE_C;
         end
         LANE_C: begin
            lane_c    = lane_c + word;
            mix_lanes();
            next_lane = LANE_A;
         end
         default: begin
            lane_a    = lane_a + word;
            next_lane = LANE_B;
         end
      endcase
      hash = lane_c;
      if (!last)
         return 1'b0;
      // partial triple gets a final mix
      if (next_lane != LANE_A)
         mix_lanes();
      next_lane = LANE_A;
      msg_open  = 1'b0;
      hash      = lane_c;
      return 1'b1;
   endfunction

   // mostly short gaps, a few long ones, none during a quiet stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_stretch || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [WORD_BITS-1:0] rand_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      if (r < 16)
         return '1;
      if (r < 24)
         return {{(WORD_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_BITS-1);
      return {$urandom, $urandom};
   endfunction

   function automatic logic [LEN_BITS-1:0] pick_len(input int nwords);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return LEN_BITS'(nwords * WORD_BITS - $urandom_range(0, WORD_BITS-1));
      if (r < 55)
         return '0;
      if (r < 65)
         return '1;
      return $urandom;
   endfunction

   // drive one req beat after a random gap and record its hash, if any
   task automatic send_beat(input logic [WORD_BITS-1:0] word,
                            input logic [LEN_BITS-1:0] len,
                            input logic last, input logic empty,
                            input logic known, input logic [WORD_BITS-1:0] known_hash);
      int                   gap;
      logic                 emits;
      logic [WORD_BITS-1:0] hash;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, word};
      req_tlast  <= last;
      req_tuser  <= empty;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      emits = hash_step(word, len, last, empty, hash);
      if (emits)
         hash_expected.push_back(known ? known_hash : hash);
      beats_sent++;
   endtask

   // hold the sender off until every predicted hash has been seen
   task automatic drain_hashes();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (hash_expected.size() != 0);
   endtask

   // rsp side: random stalls and the check of each hash beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hash_expected.size() == 0) begin
            $display("%0t ERROR unexpected hash beat: expected none actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            oldest_hash = hash_expected.pop_front();
            if (rsp_tdata !== oldest_hash) begin
               $display("%0t ERROR hash_value mismatch: expected %h actual %h",
                        $time, oldest_hash, rsp_tdata);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // stimulus
   initial begin
      int nwords;
      logic [LEN_BITS-1:0] len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tuser  = 1'b0;
      lane_a     = '0;
      lane_b     = '0;
      lane_c     = '0;
      next_lane  = LANE_A;
      msg_open   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < ROW_COUNT; i++)
         send_beat(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].last,
                   DIRECTED_ROWS[i].empty, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].hash);
      drain_hashes();

      // random messages
      while (beats_sent < ROW_COUNT + RANDOM_BEATS) begin
         if ($urandom_range(0, 99) < 12)
            quiet_stretch = !quiet_stretch;
         if ($urandom_range(0, 99) < 4)
            drain_hashes();
         // stand-alone empty message, tlast and word as noise
         if ($urandom_range(0, 99) < 10) begin
            send_beat(rand_word(), pick_len(0), 1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
            continue;
         end
         case ($urandom_range(0, 19))
            0:       nwords = $urandom_range(16, 48);
            1, 2, 3,
            4, 5:    nwords = $urandom_range(7, 15);
            default: nwords = $urandom_range(1, 6);
         endcase
         len = pick_len(nwords);
         for (int k = 0; k < nwords; k++) begin
            // now and then an empty message cuts the message short
            if (k > 0 && $urandom_range(0, 99) < 2) begin
               send_beat(rand_word(), pick_len(0), 1'($urandom_range(0, 1)), 1'b1,
                         1'b0, '0);
               break;
            end
            // length only counts on the first beat; later beats carry noise
            send_beat(rand_word(), (k == 0) ? len : LEN_BITS'($urandom),
                      k == nwords - 1, 1'b0, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      while (hash_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
